[rtl/max_tree_first_at_least_top_defines.svh]
// assertion helpers used by mtfa_ctrl
`ifndef MAX_TREE_FIRST_AT_LEAST_TOP_DEFINES_SVH
`define MAX_TREE_FIRST_AT_LEAST_TOP_DEFINES_SVH

// condition and consequence in the same cycle
`define MTFA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtfa assertion failed");

// consequence in the cycle after the condition
`define MTFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtfa assertion failed");

`endif

[rtl/mtfa_pkg.sv]
package mtfa_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 10;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  // request kinds carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic clr;       // write zero at clear counter, advance it
    logic load;      // capture accepted request
    logic wr_leaf;   // write value at leaf node
    logic rd_sib;    // read sibling of current node
    logic up;        // write parent maximum, move up
    logic rd_node;   // read current node
    logic check;     // record root compare
    logic rd_left;   // read left child of current node
    logic down;      // move to left or right child
    logic out_load;  // load result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;    // clear counter at last entry
    logic idx_ok;      // incoming leaf index within the tree
    logic near_root;   // parent of current node is the root
    logic last_inner;  // current node is on the level above the leaves
    logic ge;          // read data at least the held threshold
  } status_t;

endpackage

[rtl/mtfa_datapath.sv]
module mtfa_datapath
  import mtfa_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                     clk,
  input  cmd_t                     cmd,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_leaf_index,
  input  logic signed [DATA_W-1:0] in_leaf_value,
  input  logic signed [DATA_W-1:0] in_threshold,
  output status_t                  status,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_position
);

  localparam int LOG   = $clog2(LEAVES);
  localparam int AW    = LOG + 1;
  localparam int DEPTH = 2 * LEAVES;

  // heap-ordered maxima: root at 1, children of n at 2n and 2n+1
  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]            node_r, node_nxt;
  logic [AW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     hit_r, hit_nxt;
  logic                     out_found_r;
  logic [IDX_W-1:0]         out_pos_r;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] larger;
  logic                     ge;

  assign ge     = (rd_data_r >= val_r);
  assign larger = (val_r > rd_data_r) ? val_r : rd_data_r;

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_r;
    wr_data = val_r;
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.wr_leaf) begin
      wr_en   = 1'b1;
    end else if (cmd.up) begin
      wr_en   = 1'b1;
      wr_addr = node_r >> 1;
      wr_data = larger;
    end
    rd_en   = cmd.rd_node | cmd.rd_sib | cmd.rd_left;
    rd_addr = node_r;
    if (cmd.rd_sib) begin
      rd_addr = node_r ^ AW'(1);
    end else if (cmd.rd_left) begin
      rd_addr = node_r << 1;
    end
  end

  // tree storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // walk registers
  always_comb begin
    node_nxt    = node_r;
    val_nxt     = val_r;
    hit_nxt     = hit_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
    if (cmd.load) begin
      if (in_opcode == OP_QUERY) begin
        node_nxt = AW'(1);
        val_nxt  = in_threshold;
      end else begin
        node_nxt = AW'(LEAVES) + AW'(in_leaf_index);
        val_nxt  = in_leaf_value;
      end
    end else if (cmd.up) begin
      node_nxt = node_r >> 1;
      val_nxt  = larger;
    end else if (cmd.down) begin
      node_nxt = {node_r[AW-2:0], ~ge};
    end
    if (cmd.check) begin
      hit_nxt = ge;
    end
  end

  // clear counter starts over on every reset pass through the controller
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    val_r     <= val_nxt;
    hit_r     <= hit_nxt;
    clr_cnt_r <= cmd.clr ? clr_cnt_nxt : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= hit_r;
      out_pos_r   <= hit_r ? IDX_W'(node_r[LOG-1:0]) : '0;
    end
  end

  assign status.clr_done   = (clr_cnt_r == AW'(DEPTH - 1));
  assign status.idx_ok     = (32'(in_leaf_index) < 32'(LEAVES));
  assign status.near_root  = ((node_r >> 1) == AW'(1));
  assign status.last_inner = node_r[AW-2];
  assign status.ge         = ge;

  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

[rtl/mtfa_ctrl.sv]
`include "max_tree_first_at_least_top_defines.svh"

module mtfa_ctrl
  import mtfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_opcode,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_WLEAF = 10'b0000000100,
    S_WREAD = 10'b0000001000,
    S_WUP   = 10'b0000010000,
    S_QROOT = 10'b0000100000,
    S_QCHK  = 10'b0001000000,
    S_QREAD = 10'b0010000000,
    S_QSTEP = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  // sequencing of clear, write walk and query descent
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        // clear counter held at entry zero while reset is asserted
        cmd.clr = rst_n;
        if (status.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_opcode == OP_QUERY) begin
            state_nxt = S_QROOT;
          end else if (status.idx_ok) begin
            state_nxt = S_WLEAF;
          end
        end
      end
      S_WLEAF: begin
        cmd.wr_leaf = 1'b1;
        state_nxt   = S_WREAD;
      end
      S_WREAD: begin
        cmd.rd_sib = 1'b1;
        state_nxt  = S_WUP;
      end
      S_WUP: begin
        cmd.up    = 1'b1;
        state_nxt = status.near_root ? S_IDLE : S_WREAD;
      end
      S_QROOT: begin
        cmd.rd_node = 1'b1;
        state_nxt   = S_QCHK;
      end
      S_QCHK: begin
        cmd.check = 1'b1;
        state_nxt = status.ge ? S_QREAD : S_DONE;
      end
      S_QREAD: begin
        cmd.rd_left = 1'b1;
        state_nxt   = S_QSTEP;
      end
      S_QSTEP: begin
        cmd.down  = 1'b1;
        state_nxt = status.last_inner ? S_DONE : S_QREAD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // at most one memory write and one memory read per cycle
  `MTFA_ASSERT_SAME(a_one_write, 1'b1, $onehot0({cmd.clr, cmd.wr_leaf, cmd.up}))
  `MTFA_ASSERT_SAME(a_one_read, 1'b1, $onehot0({cmd.rd_node, cmd.rd_sib, cmd.rd_left}))
  // a pending result is never overwritten
  `MTFA_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_r || out_tready)
  // an accepted query starts at the root
  `MTFA_ASSERT_NEXT(a_query_start, accept && (in_opcode == OP_QUERY), state_r == S_QROOT)

endmodule

[rtl/max_tree_first_at_least_top.sv]
// write request: no result; query: a result, also when the root maximum is below the threshold,
// in which case the query ends after the root compare without descending
// one request in flight; each tree level costs a registered read of the single tree memory
// and then a compare (query) or a parent write (write request)
// result register lets the next request start while a result waits to be taken
// reset (rst_n low, synchronous) starts a clearing pass over every entry of the tree memory
module max_tree_first_at_least_top
  import mtfa_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // leaf_index [9:0], leaf_value [41:10], threshold [73:42], zero [79:74]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode [0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // position [9:0], zero [15:10]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // found [0]
  output logic                   out_tuser
);

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] out_position;

  mtfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .cmd        (cmd)
  );

  mtfa_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .in_opcode     (in_tuser),
    .in_leaf_index (in_tdata[IDX_W-1:0]),
    .in_leaf_value (in_tdata[IDX_W+DATA_W-1:IDX_W]),
    .in_threshold  (in_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W]),
    .status        (status),
    .out_found     (out_tuser),
    .out_position  (out_position)
  );

  assign out_tdata = {{(OUT_TDATA_W-IDX_W){1'b0}}, out_position};

endmodule
